>>> rtl/core/bmpdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Shared types and constants for the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned WidthW    = $clog2(MaxWidth + 2);
  localparam int unsigned HeightW   = $clog2(MaxHeight + 2);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] BmSignature = 16'h4D42;
  localparam logic [15:0] Depth24     = 16'd24;
  localparam logic [31:0] HeaderBytes = 32'd54;

  localparam int unsigned ColW = 12;
  localparam int unsigned RowW = 12;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StShortHdr  = 3'd1,
    StBadSig    = 3'd2,
    StBadDepth  = 3'd3,
    StTooLarge  = 3'd4,
    StBadOffset = 3'd5,
    StTrunc     = 3'd6
  } status_e;

  typedef enum logic [5:0] {
    PhHeader = 6'b000001,
    PhSkip   = 6'b000010,
    PhPixel  = 6'b000100,
    PhPad    = 6'b001000,
    PhDone   = 6'b010000,
    PhError  = 6'b100000
  } phase_e;

  // One queue entry: an optional pixel and an optional final status.
  typedef struct packed {
    logic            pix_vld;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [ColW-1:0] column;
    logic [RowW-1:0] image_row;
    logic            stat_vld;
    status_e         status;
  } q_entry_t;

endpackage

>>> rtl/core/bmpdec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpdec_front
// Header parser and pixel assembler; emits one queue entry per byte that
// completes a pixel or ends the file.
// ----------------------------------------------------------------------------
module bmpdec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_value_i,
  input  logic                end_of_file_i,
  output logic                wr_o,
  output bmpdec_pkg::q_entry_t entry_o
);

  bmpdec_pkg::phase_e              phase_q, phase_d;
  logic [31:0]                     pos_q, pos_d;
  logic [31:0]                     shift_q, shift_d;
  logic [15:0]                     sig_q, sig_d;
  logic [31:0]                     offset_q, offset_d;
  logic [bmpdec_pkg::WidthW-1:0]   width_q, width_d;
  logic [bmpdec_pkg::HeightW-1:0]  height_q, height_d;
  logic [15:0]                     depth_q, depth_d;
  logic [bmpdec_pkg::WidthW-1:0]   col_q, col_d;
  logic [bmpdec_pkg::HeightW-1:0]  row_q, row_d;
  logic [1:0]                      bip_q, bip_d;
  logic [1:0]                      pad_q, pad_d;
  logic [15:0]                     held_q, held_d;
  bmpdec_pkg::status_e             err_q, err_d;

  bmpdec_pkg::phase_e              start_phase;
  bmpdec_pkg::status_e             hdr_err;
  logic [bmpdec_pkg::HeightW-1:0]  flip_row;

  assign start_phase = (width_q == '0 || height_q == '0) ? bmpdec_pkg::PhDone
                                                         : bmpdec_pkg::PhPixel;
  assign flip_row = height_q - bmpdec_pkg::HeightW'(1) - row_q;

  always_comb begin
    priority if (sig_q != bmpdec_pkg::BmSignature) begin
      hdr_err = bmpdec_pkg::StBadSig;
    end else if (depth_q != bmpdec_pkg::Depth24) begin
      hdr_err = bmpdec_pkg::StBadDepth;
    end else if (width_q > bmpdec_pkg::WidthW'(bmpdec_pkg::MaxWidth) ||
                 height_q > bmpdec_pkg::HeightW'(bmpdec_pkg::MaxHeight)) begin
      hdr_err = bmpdec_pkg::StTooLarge;
    end else if (offset_q < bmpdec_pkg::HeaderBytes) begin
      hdr_err = bmpdec_pkg::StBadOffset;
    end else begin
      hdr_err = bmpdec_pkg::StOk;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    sig_d    = sig_q;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    col_d    = col_q;
    row_d    = row_q;
    bip_d    = bip_q;
    pad_d    = pad_q;
    held_d   = held_q;
    err_d    = err_q;
    wr_o     = 1'b0;
    entry_o  = '0;

    if (accept_i) begin
      unique case (phase_q)
        bmpdec_pkg::PhHeader: begin
          shift_d = {byte_value_i, shift_q[31:8]};
          priority case (pos_q)
            32'd1:  sig_d    = shift_d[31:16];
            32'd13: offset_d = shift_d;
            32'd21: width_d  = (shift_d > 32'(bmpdec_pkg::MaxWidth))
                               ? bmpdec_pkg::WidthW'(bmpdec_pkg::MaxWidth + 1)
                               : shift_d[bmpdec_pkg::WidthW-1:0];
            32'd25: height_d = (shift_d > 32'(bmpdec_pkg::MaxHeight))
                               ? bmpdec_pkg::HeightW'(bmpdec_pkg::MaxHeight + 1)
                               : shift_d[bmpdec_pkg::HeightW-1:0];
            32'd29: depth_d  = shift_d[31:16];
            default: ;
          endcase
          pos_d = pos_q + 32'd1;
          if (pos_d == bmpdec_pkg::HeaderBytes) begin
            if (hdr_err != bmpdec_pkg::StOk) begin
              err_d   = hdr_err;
              phase_d = bmpdec_pkg::PhError;
            end else if (offset_q == bmpdec_pkg::HeaderBytes) begin
              col_d   = '0;
              row_d   = '0;
              bip_d   = '0;
              phase_d = start_phase;
            end else begin
              phase_d = bmpdec_pkg::PhSkip;
            end
          end
        end
        bmpdec_pkg::PhSkip: begin
          // hold at all ones
          if (pos_q != '1) pos_d = pos_q + 32'd1;
          if (pos_d == offset_q) begin
            col_d   = '0;
            row_d   = '0;
            bip_d   = '0;
            phase_d = start_phase;
          end
        end
        bmpdec_pkg::PhPixel: begin
          if (bip_q == 2'd0) begin
            held_d = {held_q[15:8], byte_value_i};
            bip_d  = 2'd1;
          end else if (bip_q == 2'd1) begin
            held_d = {byte_value_i, held_q[7:0]};
            bip_d  = 2'd2;
          end else begin
            wr_o              = 1'b1;
            entry_o.pix_vld   = 1'b1;
            entry_o.red       = byte_value_i;
            entry_o.green     = held_q[15:8];
            entry_o.blue      = held_q[7:0];
            entry_o.column    = bmpdec_pkg::ColW'(col_q);
            entry_o.image_row = bmpdec_pkg::RowW'(flip_row);
            bip_d = 2'd0;
            col_d = col_q + bmpdec_pkg::WidthW'(1);
            if (col_d >= width_q) begin
              pad_d = width_q[1:0];
              if (width_q[1:0] != 2'd0) begin
                phase_d = bmpdec_pkg::PhPad;
              end else begin
                col_d   = '0;
                row_d   = row_q + bmpdec_pkg::HeightW'(1);
                phase_d = (row_d >= height_q) ? bmpdec_pkg::PhDone : bmpdec_pkg::PhPixel;
              end
            end
          end
        end
        bmpdec_pkg::PhPad: begin
          if (pad_q != 2'd0) pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) begin
            col_d   = '0;
            row_d   = row_q + bmpdec_pkg::HeightW'(1);
            phase_d = (row_d >= height_q) ? bmpdec_pkg::PhDone : bmpdec_pkg::PhPixel;
          end
        end
        default: ;
      endcase

      if (end_of_file_i) begin
        wr_o             = 1'b1;
        entry_o.stat_vld = 1'b1;
        unique case (phase_d)
          bmpdec_pkg::PhHeader: entry_o.status = bmpdec_pkg::StShortHdr;
          bmpdec_pkg::PhError:  entry_o.status = err_d;
          bmpdec_pkg::PhDone:   entry_o.status = bmpdec_pkg::StOk;
          default:              entry_o.status = bmpdec_pkg::StTrunc;
        endcase
        // drop all file state for the next file
        phase_d  = bmpdec_pkg::PhHeader;
        pos_d    = '0;
        shift_d  = '0;
        sig_d    = '0;
        offset_d = '0;
        width_d  = '0;
        height_d = '0;
        depth_d  = '0;
        col_d    = '0;
        row_d    = '0;
        bip_d    = '0;
        pad_d    = '0;
        held_d   = '0;
        err_d    = bmpdec_pkg::StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bmpdec_pkg::PhHeader;
      pos_q    <= '0;
      shift_q  <= '0;
      sig_q    <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      col_q    <= '0;
      row_q    <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
      held_q   <= '0;
      err_q    <= bmpdec_pkg::StOk;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      sig_q    <= sig_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
      held_q   <= held_d;
      err_q    <= err_d;
    end
  end

endmodule

>>> rtl/core/bmpdec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpdec_queue
// Small flop queue of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module bmpdec_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_i,
  input  bmpdec_pkg::q_entry_t                wr_data_i,
  input  logic                                rd_i,
  output bmpdec_pkg::q_entry_t                rd_data_o,
  output logic                                full_o,
  output logic                                empty_o,
  output logic [bmpdec_pkg::QCntW-1:0]        count_o
);

  bmpdec_pkg::q_entry_t              mem_q [bmpdec_pkg::QueueDepth];
  logic [bmpdec_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bmpdec_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bmpdec_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                              do_wr, do_rd;

  assign full_o    = (cnt_q == bmpdec_pkg::QCntW'(bmpdec_pkg::QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign count_o   = cnt_q;
  assign rd_data_o = mem_q[rd_ptr_q];

  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == bmpdec_pkg::QPtrW'(bmpdec_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + bmpdec_pkg::QPtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == bmpdec_pkg::QPtrW'(bmpdec_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + bmpdec_pkg::QPtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + bmpdec_pkg::QCntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - bmpdec_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

>>> rtl/core/bmpdec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpdec_back
// Output stage: unpacks each queue entry into a pixel result, a status
// result, or a pixel followed by a status.
// ----------------------------------------------------------------------------
module bmpdec_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmpdec_pkg::q_entry_t          q_data_i,
  input  logic                          q_empty_i,
  output logic                          q_rd_o,
  input  logic                          pop,
  output logic                          empty,
  output logic                          kind_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [bmpdec_pkg::ColW-1:0]   column_o,
  output logic [bmpdec_pkg::RowW-1:0]   image_row_o,
  output logic [2:0]                    status_o
);

  bmpdec_pkg::q_entry_t entry_q, entry_d;
  logic                 pix_q, pix_d;
  logic                 stat_q, stat_d;
  logic                 xfer;
  logic                 pix_left, stat_left;

  assign empty = !(pix_q || stat_q);
  assign xfer  = pop && !empty;

  assign pix_left  = pix_q && !xfer;
  assign stat_left = stat_q && !(xfer && !pix_q);

  always_comb begin
    entry_d = entry_q;
    pix_d   = pix_left;
    stat_d  = stat_left;
    q_rd_o  = 1'b0;
    // load the next entry once the current one is fully transferred
    if (!pix_left && !stat_left && !q_empty_i) begin
      q_rd_o  = 1'b1;
      entry_d = q_data_i;
      pix_d   = q_data_i.pix_vld;
      stat_d  = q_data_i.stat_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q  <= 1'b0;
      stat_q <= 1'b0;
    end else begin
      pix_q  <= pix_d;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign kind_o      = !pix_q;
  assign red_o       = pix_q ? entry_q.red       : 8'd0;
  assign green_o     = pix_q ? entry_q.green     : 8'd0;
  assign blue_o      = pix_q ? entry_q.blue      : 8'd0;
  assign column_o    = pix_q ? entry_q.column    : '0;
  assign image_row_o = pix_q ? entry_q.image_row : '0;
  assign status_o    = pix_q ? 3'd0 : 3'(entry_q.status);

endmodule

>>> rtl/core/bmp_24bit_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_24bit_stream_decoder_core
// Byte-serial decoder for uncompressed 24-bit BMP files: header checks,
// offset skip, B,G,R to pixel with column and flipped row, one final status.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake     | Payload
//  --------+-----------+---------------+------------------------------------
//  bytes   | in        | push / full   | byte_value_i, end_of_file_i
//  results | out       | empty / pop   | kind_o, red_o, green_o, blue_o,
//          |           |               | column_o, image_row_o, status_o
//
//  One byte is taken per cycle while full is low; the parser settles each
//  byte in the cycle it is taken. Each result is written into the queue at
//  the edge that transfers its byte, then loaded into the output stage
//  register once that stage is free. The final byte of a file with a pixel
//  on it gives two results, the pixel and then the status. A four-entry
//  queue lets the parser run on while the result side stalls; full rises when that queue fills.
//  Reset is asynchronous, active low, and leaves the decoder ready for a file.
// ----------------------------------------------------------------------------
module bmp_24bit_stream_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    byte_value_i,
  input  logic                          end_of_file_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [bmpdec_pkg::ColW-1:0]   column_o,
  output logic [bmpdec_pkg::RowW-1:0]   image_row_o,
  output logic [2:0]                    status_o
);

  logic                          accept;
  logic                          fe_wr;
  bmpdec_pkg::q_entry_t          fe_entry;
  bmpdec_pkg::q_entry_t          q_data;
  logic                          q_empty;
  logic                          q_rd;
  logic [bmpdec_pkg::QCntW-1:0]  q_count;

  assign accept = push && !full;

  bmpdec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_value_i  (byte_value_i),
    .end_of_file_i (end_of_file_i),
    .wr_o          (fe_wr),
    .entry_o       (fe_entry)
  );

  bmpdec_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fe_wr),
    .wr_data_i (fe_entry),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (full),
    .empty_o   (q_empty),
    .count_o   (q_count)
  );

  bmpdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_data),
    .q_empty_i   (q_empty),
    .q_rd_o      (q_rd),
    .pop         (pop),
    .empty       (empty),
    .kind_o      (kind_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .column_o    (column_o),
    .image_row_o (image_row_o),
    .status_o    (status_o)
  );

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= bmpdec_pkg::QCntW'(bmpdec_pkg::QueueDepth))
    else $error("result queue count above depth");

  a_eof_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_file_i) |=> (q_count != '0))
    else $error("end of file transfer left no queued status");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |-> (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0 &&
                            column_o == '0 && image_row_o == '0))
    else $error("status result carries pixel data");

  a_pixel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !kind_o) |-> (status_o == 3'd0))
    else $error("pixel result carries a status");

endmodule
